// ----- rtl/core/zcd_pkg.sv -----
package zcd_pkg;

  localparam int TICK_BITS = 16;
  localparam int SUM_BITS  = 32;
  localparam int LEG_BITS  = 31;
  localparam int THR_BITS  = 10;
  localparam int PIX_BITS  = 8;
  localparam int CFG_ADDR_BITS = 3;

  localparam logic [PIX_BITS-1:0] WHITE_LEVEL = 8'hFF;
  localparam logic [PIX_BITS-1:0] BLACK_LEVEL = 8'h00;

  localparam logic signed [SUM_BITS-1:0] SUM_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [SUM_BITS-1:0] SUM_MIN = 32'sh8000_0000;

  // Register reset values
  localparam int RST_ROW_FIRST = 25;
  localparam int RST_ROW_LAST  = 43;
  localparam int RST_COL_FIRST = 30;
  localparam int RST_COL_LAST  = 63;
  localparam int RST_THRESHOLD = 25;
  localparam int RST_FIRST_LEG = 10500;
  localparam int RST_SECOND_LEG = 21000;
  localparam int RST_STOP_LEG  = 7000;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_ROW_FIRST  = 3'd0,
    REG_ROW_LAST   = 3'd1,
    REG_COL_FIRST  = 3'd2,
    REG_COL_LAST   = 3'd3,
    REG_THRESHOLD  = 3'd4,
    REG_FIRST_LEG  = 3'd5,
    REG_SECOND_LEG = 3'd6,
    REG_STOP_LEG   = 3'd7
  } cfg_reg_t;

  typedef enum logic {
    KIND_PIXEL     = 1'b0,
    KIND_FRAME_END = 1'b1
  } item_kind_t;

  typedef enum logic [2:0] {
    ST_SEARCH     = 3'd0,
    ST_FIRST_LEG  = 3'd1,
    ST_SECOND_LEG = 3'd2,
    ST_CONFIRM    = 3'd3,
    ST_STOP_LEG   = 3'd4,
    ST_STOPPED    = 3'd5
  } crossing_state_t;

  typedef struct packed {
    logic [THR_BITS-1:0] threshold;
    logic [LEG_BITS-1:0] first_leg;
    logic [LEG_BITS-1:0] second_leg;
    logic [LEG_BITS-1:0] stop_leg;
  } legs_cfg_t;

  typedef struct packed {
    logic ramp_active;
    logic picture_idle;
    logic other_active;
    logic clear_distance;
  } frame_flags_t;

endpackage

// ----- rtl/core/zcd_window_counter.sv -----
module zcd_window_counter #(
  parameter int ROW_BITS   = 7,
  parameter int COL_BITS   = 8,
  parameter int COUNT_BITS = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         pixel_stb,
  input  logic                         frame_stb,
  input  logic [zcd_pkg::PIX_BITS-1:0] pixel_value,
  input  logic [ROW_BITS-1:0]          pixel_row,
  input  logic [COL_BITS-1:0]          pixel_col,
  input  logic [ROW_BITS-1:0]          row_first,
  input  logic [ROW_BITS-1:0]          row_last,
  input  logic [COL_BITS-1:0]          col_first,
  input  logic [COL_BITS-1:0]          col_last,
  output logic [COUNT_BITS-1:0]        count
);

  logic                prev_white;
  logic [COL_BITS-1:0] white_col;
  logic                in_rows;
  logic                in_cols;
  logic                hit;

  // The white pixel of a transition sits one column to the left
  assign white_col = pixel_col - COL_BITS'(1);
  assign in_rows   = (pixel_row >= row_first) && (pixel_row <= row_last);
  assign in_cols   = (pixel_col != '0) && (white_col >= col_first) &&
                     (white_col <= col_last);
  assign hit       = (pixel_value == zcd_pkg::BLACK_LEVEL) && prev_white &&
                     in_rows && in_cols && (count != {COUNT_BITS{1'b1}});

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_white <= 1'b0;
      count      <= '0;
    end else if (frame_stb) begin
      prev_white <= 1'b0;
      count      <= '0;
    end else if (pixel_stb) begin
      prev_white <= (pixel_value == zcd_pkg::WHITE_LEVEL);
      if (hit) begin
        count <= count + COUNT_BITS'(1);
      end
    end
  end

endmodule

// ----- rtl/core/zcd_crossing_fsm.sv -----
module zcd_crossing_fsm #(
  parameter int COUNT_BITS = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                frame_stb,
  input  logic [COUNT_BITS-1:0]               count,
  input  zcd_pkg::legs_cfg_t                  legs,
  input  zcd_pkg::frame_flags_t               flags,
  input  logic signed [zcd_pkg::TICK_BITS-1:0] left_ticks,
  input  logic signed [zcd_pkg::TICK_BITS-1:0] right_ticks,
  output zcd_pkg::crossing_state_t            state_next,
  output logic                                stop_next,
  output logic signed [zcd_pkg::SUM_BITS-1:0] sum_next
);

  localparam int CmpBits = (COUNT_BITS > zcd_pkg::THR_BITS) ? COUNT_BITS : zcd_pkg::THR_BITS;
  localparam int WideBits = zcd_pkg::SUM_BITS + 2;

  zcd_pkg::crossing_state_t           state;
  logic signed [zcd_pkg::SUM_BITS-1:0] accum;

  logic                                stripes;
  logic                                accumulate;
  logic signed [zcd_pkg::SUM_BITS-1:0] base_sum;
  logic        [WideBits-1:0]          wide;
  logic signed [zcd_pkg::SUM_BITS-1:0] added;
  logic signed [zcd_pkg::SUM_BITS-1:0] first_lim;
  logic signed [zcd_pkg::SUM_BITS-1:0] second_lim;
  logic signed [zcd_pkg::SUM_BITS-1:0] stop_lim;

  assign stripes    = CmpBits'(count) > CmpBits'(legs.threshold);
  assign first_lim  = $signed({1'b0, legs.first_leg});
  assign second_lim = $signed({1'b0, legs.second_leg});
  assign stop_lim   = $signed({1'b0, legs.stop_leg});

  assign base_sum   = flags.clear_distance ? '0 : accum;
  assign accumulate = (state == zcd_pkg::ST_FIRST_LEG) || (state == zcd_pkg::ST_SECOND_LEG) ||
                      (state == zcd_pkg::ST_STOP_LEG) || flags.other_active;
  assign wide = {{2{base_sum[zcd_pkg::SUM_BITS-1]}}, base_sum} +
                {{(WideBits-zcd_pkg::TICK_BITS){left_ticks[zcd_pkg::TICK_BITS-1]}}, left_ticks} +
                {{(WideBits-zcd_pkg::TICK_BITS){right_ticks[zcd_pkg::TICK_BITS-1]}}, right_ticks};

  // Saturate when the top three bits disagree
  always_comb begin
    if ((wide[WideBits-1:zcd_pkg::SUM_BITS-1] == 3'b000) ||
        (wide[WideBits-1:zcd_pkg::SUM_BITS-1] == 3'b111)) begin
      added = $signed(wide[zcd_pkg::SUM_BITS-1:0]);
    end else if (wide[WideBits-1]) begin
      added = zcd_pkg::SUM_MIN;
    end else begin
      added = zcd_pkg::SUM_MAX;
    end
  end

  // Cascade: one frame may pass through several states
  always_comb begin
    sum_next   = accumulate ? added : base_sum;
    state_next = state;
    stop_next  = 1'b0;
    if (state_next == zcd_pkg::ST_SEARCH && stripes) begin
      state_next = zcd_pkg::ST_FIRST_LEG;
    end
    if (state_next == zcd_pkg::ST_FIRST_LEG && sum_next > first_lim) begin
      state_next = zcd_pkg::ST_SECOND_LEG;
      sum_next   = '0;
    end
    if (state_next == zcd_pkg::ST_SECOND_LEG && sum_next > second_lim) begin
      state_next = zcd_pkg::ST_CONFIRM;
      sum_next   = '0;
    end
    if (state_next == zcd_pkg::ST_CONFIRM && stripes && !flags.ramp_active &&
        flags.picture_idle) begin
      state_next = zcd_pkg::ST_STOP_LEG;
    end
    if (state_next == zcd_pkg::ST_STOP_LEG && sum_next > stop_lim) begin
      state_next = zcd_pkg::ST_STOPPED;
      stop_next  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= zcd_pkg::ST_SEARCH;
      accum <= '0;
    end else if (frame_stb) begin
      state <= state_next;
      accum <= sum_next;
    end
  end

endmodule

// ----- rtl/core/zebra_crossing_detector.sv -----
// Zebra crossing detector. Binarized pixels and frame-end items share one input
// stream (tuser 0 pixel, 1 frame end). Pixels count white-to-black transitions
// inside the configured row and column window; each frame-end item updates the
// encoder distance sum, steps the crossing state machine and returns one result
// transfer, while pixels return nothing. The block takes one item per clock
// while ready is high: an input register feeds a single combinational step into
// the result register, loaded as a frame-end item leaves the input register.
// Input ready drops only while a result waits in the output register and the
// next item in the input register is a frame end. Configuration writes take
// effect on the next clock and are meant for idle periods.
module zebra_crossing_detector #(
  parameter int ROW_BITS   = 7,
  parameter int COL_BITS   = 8,
  parameter int COUNT_BITS = 10,
  localparam int IN_BITS   = zcd_pkg::PIX_BITS + ROW_BITS + COL_BITS + 2 * zcd_pkg::TICK_BITS + 4,
  localparam int IN_DATA_BITS  = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS  = 3 + 1 + COUNT_BITS + zcd_pkg::SUM_BITS,
  localparam int OUT_DATA_BITS = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // pixel_value, pixel_row, pixel_col, left_ticks, right_ticks, ramp_active,
  // picture_idle, other_active, clear_distance
  input  logic [IN_DATA_BITS-1:0]           s_axis_tdata,
  // func
  input  logic [0:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // zebra_state, stop_pulse, transition_total, distance_sum
  output logic [OUT_DATA_BITS-1:0]          m_axis_tdata,
  input  logic                              cfg_we,
  input  logic [zcd_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [zcd_pkg::LEG_BITS-1:0]      cfg_data
);

  localparam int RowLsb   = zcd_pkg::PIX_BITS;
  localparam int ColLsb   = RowLsb + ROW_BITS;
  localparam int LeftLsb  = ColLsb + COL_BITS;
  localparam int RightLsb = LeftLsb + zcd_pkg::TICK_BITS;
  localparam int RampBit  = RightLsb + zcd_pkg::TICK_BITS;
  localparam int PicBit   = RampBit + 1;
  localparam int OtherBit = RampBit + 2;
  localparam int ClearBit = RampBit + 3;

  // Configuration registers
  logic [ROW_BITS-1:0]     row_first;
  logic [ROW_BITS-1:0]     row_last;
  logic [COL_BITS-1:0]     col_first;
  logic [COL_BITS-1:0]     col_last;
  zcd_pkg::legs_cfg_t      legs;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_first       <= ROW_BITS'(zcd_pkg::RST_ROW_FIRST);
      row_last        <= ROW_BITS'(zcd_pkg::RST_ROW_LAST);
      col_first       <= COL_BITS'(zcd_pkg::RST_COL_FIRST);
      col_last        <= COL_BITS'(zcd_pkg::RST_COL_LAST);
      legs.threshold  <= zcd_pkg::THR_BITS'(zcd_pkg::RST_THRESHOLD);
      legs.first_leg  <= zcd_pkg::LEG_BITS'(zcd_pkg::RST_FIRST_LEG);
      legs.second_leg <= zcd_pkg::LEG_BITS'(zcd_pkg::RST_SECOND_LEG);
      legs.stop_leg   <= zcd_pkg::LEG_BITS'(zcd_pkg::RST_STOP_LEG);
    end else if (cfg_we) begin
      case (zcd_pkg::cfg_reg_t'(cfg_addr))
        zcd_pkg::REG_ROW_FIRST:  row_first       <= cfg_data[ROW_BITS-1:0];
        zcd_pkg::REG_ROW_LAST:   row_last        <= cfg_data[ROW_BITS-1:0];
        zcd_pkg::REG_COL_FIRST:  col_first       <= cfg_data[COL_BITS-1:0];
        zcd_pkg::REG_COL_LAST:   col_last        <= cfg_data[COL_BITS-1:0];
        zcd_pkg::REG_THRESHOLD:  legs.threshold  <= cfg_data[zcd_pkg::THR_BITS-1:0];
        zcd_pkg::REG_FIRST_LEG:  legs.first_leg  <= cfg_data;
        zcd_pkg::REG_SECOND_LEG: legs.second_leg <= cfg_data;
        zcd_pkg::REG_STOP_LEG:   legs.stop_leg   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  logic                    in_valid;
  zcd_pkg::item_kind_t     in_kind;
  logic [IN_BITS-1:0]      in_data;
  logic                    out_free;
  logic                    advance;
  logic                    pixel_stb;
  logic                    frame_stb;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign advance       = in_valid && ((in_kind == zcd_pkg::KIND_PIXEL) || out_free);
  assign pixel_stb     = advance && (in_kind == zcd_pkg::KIND_PIXEL);
  assign frame_stb     = advance && (in_kind == zcd_pkg::KIND_FRAME_END);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_kind <= zcd_pkg::item_kind_t'(s_axis_tuser[0]);
      in_data <= s_axis_tdata[IN_BITS-1:0];
    end
  end

  zcd_pkg::frame_flags_t flags;
  assign flags.ramp_active    = in_data[RampBit];
  assign flags.picture_idle   = in_data[PicBit];
  assign flags.other_active   = in_data[OtherBit];
  assign flags.clear_distance = in_data[ClearBit];

  logic [COUNT_BITS-1:0]               count;
  zcd_pkg::crossing_state_t            state_next;
  logic                                stop_next;
  logic signed [zcd_pkg::SUM_BITS-1:0] sum_next;

  zcd_window_counter #(
    .ROW_BITS  (ROW_BITS),
    .COL_BITS  (COL_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_counter (
    .clk        (clk),
    .rst        (rst),
    .pixel_stb  (pixel_stb),
    .frame_stb  (frame_stb),
    .pixel_value(in_data[zcd_pkg::PIX_BITS-1:0]),
    .pixel_row  (in_data[ColLsb-1:RowLsb]),
    .pixel_col  (in_data[LeftLsb-1:ColLsb]),
    .row_first  (row_first),
    .row_last   (row_last),
    .col_first  (col_first),
    .col_last   (col_last),
    .count      (count)
  );

  zcd_crossing_fsm #(
    .COUNT_BITS(COUNT_BITS)
  ) u_fsm (
    .clk        (clk),
    .rst        (rst),
    .frame_stb  (frame_stb),
    .count      (count),
    .legs       (legs),
    .flags      (flags),
    .left_ticks ($signed(in_data[RightLsb-1:LeftLsb])),
    .right_ticks($signed(in_data[RampBit-1:RightLsb])),
    .state_next (state_next),
    .stop_next  (stop_next),
    .sum_next   (sum_next)
  );

  // Result register
  logic [OUT_BITS-1:0] result;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (frame_stb) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_stb) begin
      result <= {sum_next, count, stop_next, state_next};
    end
  end

  assign m_axis_tdata = OUT_DATA_BITS'(result);

endmodule

// ----- tb/tb_zebra_crossing_detector.sv -----
`timescale 1ns / 100ps

module tb_zebra_crossing_detector;

  localparam int IN_W       = 64;
  localparam int OUT_W      = 48;
  localparam int LEG_MAX    = 2147483647;
  localparam int HOLD_LONG  = 400;
  localparam int SETTLE     = 4;
  localparam int DRAIN_MAX  = 20000;

  typedef struct packed {
    zcd_pkg::item_kind_t kind;
    logic [7:0]  value;
    logic [6:0]  row;
    logic [7:0]  col;
    logic [15:0] left;
    logic [15:0] right;
    logic        ramp;
    logic        pic_idle;
    logic        other;
    logic        clr;
  } zcd_item_t;

  typedef struct packed {
    logic [31:0] distance;
    logic [9:0]  total;
    logic        stop;
    logic [2:0]  state;
  } crossing_result_t;

  typedef struct packed {
    logic [6:0]  row_first;
    logic [6:0]  row_last;
    logic [7:0]  col_first;
    logic [7:0]  col_last;
    logic [9:0]  threshold;
    logic [30:0] first_leg;
    logic [30:0] second_leg;
    logic [30:0] stop_leg;
  } zcd_regs_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata;
  logic [0:0]       s_axis_tuser;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             cfg_we;
  logic [2:0]       cfg_addr;
  logic [30:0]      cfg_data;

  // detector copy kept alongside the block
  zcd_regs_t                model_regs;
  bit                       model_was_white;
  logic [9:0]               model_stripes;
  longint                   model_distance;
  zcd_pkg::crossing_state_t model_state;
  crossing_result_t         frame_results[$];

  bit idle_on;
  bit hold_request;
  int err_count;
  int items_sent;
  int pixels_sent;
  int frames_sent;
  int results_checked;
  int deepest_state;

  always #2 clk = ~clk;

  zebra_crossing_detector dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_data     (cfg_data)
  );

  function automatic zcd_regs_t make_regs(input int rf, input int rl, input int cf,
                                          input int cl, input int thr, input int l1,
                                          input int l2, input int l3);
    zcd_regs_t r;
    r.row_first  = 7'(rf);
    r.row_last   = 7'(rl);
    r.col_first  = 8'(cf);
    r.col_last   = 8'(cl);
    r.threshold  = 10'(thr);
    r.first_leg  = 31'(l1);
    r.second_leg = 31'(l2);
    r.stop_leg   = 31'(l3);
    return r;
  endfunction

  function automatic logic [30:0] random_leg();
    case ($urandom_range(0, 9))
      0: return 31'd0;
      1: return 31'(LEG_MAX);
      default: return 31'($urandom_range(0, 30000));
    endcase
  endfunction

  function automatic zcd_regs_t random_regs(input bit allow_stop);
    zcd_regs_t r;
    int lo;
    int hi;
    case ($urandom_range(0, 5))
      0: begin
        r.row_first = 7'd0;
        r.row_last  = 7'h7F;
        r.col_first = 8'd0;
        r.col_last  = 8'hFF;
      end
      1: begin
        // first above last: nothing counts
        r.row_first = 7'($urandom_range(1, 127));
        r.row_last  = 7'($urandom_range(0, r.row_first - 1));
        r.col_first = 8'($urandom_range(1, 255));
        r.col_last  = 8'($urandom_range(0, r.col_first - 1));
      end
      default: begin
        lo = $urandom_range(0, 127);
        hi = lo + $urandom_range(0, 6);
        r.row_first = 7'(lo);
        r.row_last  = 7'((hi > 127) ? 127 : hi);
        lo = $urandom_range(0, 255);
        hi = lo + $urandom_range(0, 12);
        r.col_first = 8'(lo);
        r.col_last  = 8'((hi > 255) ? 255 : hi);
      end
    endcase
    case ($urandom_range(0, 11))
      0: r.threshold = 10'd0;
      1: r.threshold = 10'h3FF;
      default: r.threshold = 10'($urandom_range(0, 5));
    endcase
    r.first_leg  = random_leg();
    r.second_leg = random_leg();
    r.stop_leg   = allow_stop ? random_leg() : 31'(LEG_MAX);
    return r;
  endfunction

  function automatic logic [15:0] random_ticks();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2, 3: return 16'($urandom);
      default: return 16'($urandom_range(0, 3400) - 200);
    endcase
  endfunction

  function automatic void predict_crossing(input zcd_item_t it);
    crossing_result_t res;
    logic [7:0] left_col;
    bit stop;
    stop = 1'b0;
    if (it.kind == zcd_pkg::KIND_PIXEL) begin
      pixels_sent++;
      left_col = it.col - 8'd1;
      if (it.value == zcd_pkg::BLACK_LEVEL && model_was_white && it.col != 8'd0 &&
          it.row >= model_regs.row_first && it.row <= model_regs.row_last &&
          left_col >= model_regs.col_first && left_col <= model_regs.col_last &&
          model_stripes != '1)
        model_stripes++;
      model_was_white = (it.value == zcd_pkg::WHITE_LEVEL);
      return;
    end
    frames_sent++;
    if (it.clr)
      model_distance = 0;
    if (model_state == zcd_pkg::ST_FIRST_LEG || model_state == zcd_pkg::ST_SECOND_LEG ||
        model_state == zcd_pkg::ST_STOP_LEG || it.other) begin
      model_distance = model_distance + longint'($signed(it.left)) +
                       longint'($signed(it.right));
      if (model_distance > longint'(zcd_pkg::SUM_MAX))
        model_distance = longint'(zcd_pkg::SUM_MAX);
      if (model_distance < longint'(zcd_pkg::SUM_MIN))
        model_distance = longint'(zcd_pkg::SUM_MIN);
    end
    // cascade: one frame may pass through several states
    if (model_state == zcd_pkg::ST_SEARCH && model_stripes > model_regs.threshold)
      model_state = zcd_pkg::ST_FIRST_LEG;
    if (model_state == zcd_pkg::ST_FIRST_LEG &&
        model_distance > longint'(model_regs.first_leg)) begin
      model_state = zcd_pkg::ST_SECOND_LEG;
      model_distance = 0;
    end
    if (model_state == zcd_pkg::ST_SECOND_LEG &&
        model_distance > longint'(model_regs.second_leg)) begin
      model_state = zcd_pkg::ST_CONFIRM;
      model_distance = 0;
    end
    if (model_state == zcd_pkg::ST_CONFIRM && model_stripes > model_regs.threshold &&
        !it.ramp && it.pic_idle)
      model_state = zcd_pkg::ST_STOP_LEG;
    if (model_state == zcd_pkg::ST_STOP_LEG &&
        model_distance > longint'(model_regs.stop_leg)) begin
      model_state = zcd_pkg::ST_STOPPED;
      stop = 1'b1;
    end
    if (int'(model_state) > deepest_state)
      deepest_state = int'(model_state);
    res.state    = model_state;
    res.stop     = stop;
    res.total    = model_stripes;
    res.distance = 32'(model_distance);
    frame_results.push_back(res);
    model_stripes = '0;
    model_was_white = 1'b0;
  endfunction

  task automatic push_item(input zcd_item_t it);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.kind;
    s_axis_tdata  <= {5'b0, it.clr, it.other, it.pic_idle, it.ramp, it.right, it.left,
                      it.col, it.row, it.value};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
    predict_crossing(it);
  endtask

  task automatic send_pixel(input logic [7:0] v, input logic [6:0] r, input logic [7:0] c);
    zcd_item_t it;
    it.left  = 16'($urandom);
    it.right = 16'($urandom);
    {it.ramp, it.pic_idle, it.other, it.clr} = 4'($urandom);
    it.kind  = zcd_pkg::KIND_PIXEL;
    it.value = v;
    it.row   = r;
    it.col   = c;
    push_item(it);
  endtask

  task automatic send_frame_end(input logic [15:0] l, input logic [15:0] r,
                                input logic ramp, input logic pic, input logic other,
                                input logic clr);
    zcd_item_t it;
    it.value    = 8'($urandom);
    it.row      = 7'($urandom);
    it.col      = 8'($urandom);
    it.kind     = zcd_pkg::KIND_FRAME_END;
    it.left     = l;
    it.right    = r;
    it.ramp     = ramp;
    it.pic_idle = pic;
    it.other    = other;
    it.clr      = clr;
    push_item(it);
  endtask

  task automatic send_random_frame_end();
    send_frame_end(random_ticks(), random_ticks(), $urandom_range(0, 3) == 0,
                   $urandom_range(0, 3) != 0, $urandom_range(0, 1) == 1,
                   $urandom_range(0, 9) == 0);
  endtask

  // alternating white/black run near the window, with stray pixels mixed in
  task automatic send_stripes(input int n);
    logic [6:0] row;
    logic [7:0] col;
    int lo_col;
    if (model_regs.row_first <= model_regs.row_last && $urandom_range(0, 5) != 0)
      row = 7'($urandom_range(model_regs.row_first, model_regs.row_last));
    else
      row = 7'($urandom);
    lo_col = (model_regs.col_first >= 2) ? model_regs.col_first - 2 : 0;
    if (lo_col <= model_regs.col_last)
      col = 8'($urandom_range(lo_col, model_regs.col_last));
    else
      col = 8'($urandom);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 11))
        0: send_pixel(8'($urandom), 7'($urandom), 8'($urandom));
        1: begin
          send_pixel(8'($urandom), row, col);
          col++;
        end
        default: begin
          send_pixel((i % 2 == 0) ? zcd_pkg::WHITE_LEVEL : zcd_pkg::BLACK_LEVEL, row, col);
          col++;
        end
      endcase
    end
  endtask

  // drain results, then let the pipeline settle with the input idle
  task automatic wait_idle();
    int waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    while (frame_results.size() != 0 && waited < DRAIN_MAX) begin
      @(posedge clk);
      waited++;
    end
    if (frame_results.size() != 0) begin
      $display("%0t: %0d frame results never arrived", $time, frame_results.size());
      err_count++;
      frame_results.delete();
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic program_regs(input zcd_regs_t r);
    zcd_pkg::cfg_reg_t idx;
    for (int i = 0; i < 8; i++) begin
      idx = zcd_pkg::cfg_reg_t'(i);
      cfg_we   <= 1'b1;
      cfg_addr <= idx;
      case (idx)
        zcd_pkg::REG_ROW_FIRST:  cfg_data <= 31'(r.row_first);
        zcd_pkg::REG_ROW_LAST:   cfg_data <= 31'(r.row_last);
        zcd_pkg::REG_COL_FIRST:  cfg_data <= 31'(r.col_first);
        zcd_pkg::REG_COL_LAST:   cfg_data <= 31'(r.col_last);
        zcd_pkg::REG_THRESHOLD:  cfg_data <= 31'(r.threshold);
        zcd_pkg::REG_FIRST_LEG:  cfg_data <= r.first_leg;
        zcd_pkg::REG_SECOND_LEG: cfg_data <= r.second_leg;
        zcd_pkg::REG_STOP_LEG:   cfg_data <= r.stop_leg;
        default:                 cfg_data <= '0;
      endcase
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    model_regs = r;
  endtask

  // reset window: edges of rows and columns, stray values, encoder extremes
  task automatic test_pixel_cases();
    send_pixel(zcd_pkg::WHITE_LEVEL, 7'd25, 8'd30);
    send_pixel(zcd_pkg::BLACK_LEVEL, 7'd25, 8'd31);
    send_pixel(zcd_pkg::WHITE_LEVEL, 7'd43, 8'd63);
    send_pixel(zcd_pkg::BLACK_LEVEL, 7'd43, 8'd64);
    send_pixel(zcd_pkg::WHITE_LEVEL, 7'd24, 8'd40);
    send_pixel(zcd_pkg::BLACK_LEVEL, 7'd24, 8'd41);
    send_pixel(zcd_pkg::WHITE_LEVEL, 7'd44, 8'd40);
    send_pixel(zcd_pkg::BLACK_LEVEL, 7'd44, 8'd41);
    send_pixel(zcd_pkg::WHITE_LEVEL, 7'd30, 8'd29);
    send_pixel(zcd_pkg::BLACK_LEVEL, 7'd30, 8'd30);
    send_pixel(zcd_pkg::WHITE_LEVEL, 7'd30, 8'd64);
    send_pixel(zcd_pkg::BLACK_LEVEL, 7'd30, 8'd65);
    send_pixel(zcd_pkg::WHITE_LEVEL, 7'd30, 8'd40);
    send_pixel(8'd128, 7'd30, 8'd41);
    send_pixel(zcd_pkg::BLACK_LEVEL, 7'd30, 8'd42);
    send_pixel(8'd254, 7'd31, 8'd40);
    send_pixel(zcd_pkg::BLACK_LEVEL, 7'd31, 8'd41);
    send_frame_end(16'h7FFF, 16'h7FFF, 1'b0, 1'b1, 1'b1, 1'b0);
    send_frame_end(16'h8000, 16'h8000, 1'b1, 1'b0, 1'b1, 1'b1);
    send_frame_end(16'h0001, 16'hFFFF, 1'b0, 1'b1, 1'b0, 1'b1);
  endtask

  task automatic test_window_extremes();
    wait_idle();
    program_regs(make_regs(0, 127, 0, 255, 1023, LEG_MAX, LEG_MAX, LEG_MAX));
    // white at the last column, black at column zero of the next row
    send_pixel(zcd_pkg::WHITE_LEVEL, 7'd10, 8'd255);
    send_pixel(zcd_pkg::BLACK_LEVEL, 7'd11, 8'd0);
    send_pixel(zcd_pkg::WHITE_LEVEL, 7'd0, 8'd0);
    send_pixel(zcd_pkg::BLACK_LEVEL, 7'd0, 8'd1);
    send_pixel(zcd_pkg::WHITE_LEVEL, 7'd127, 8'd254);
    send_pixel(zcd_pkg::BLACK_LEVEL, 7'd127, 8'd255);
    send_frame_end(16'd0, 16'd0, 1'b0, 1'b1, 1'b0, 1'b0);
    wait_idle();
    program_regs(make_regs(43, 25, 63, 30, 0, 0, 0, 0));
    send_pixel(zcd_pkg::WHITE_LEVEL, 7'd30, 8'd40);
    send_pixel(zcd_pkg::BLACK_LEVEL, 7'd30, 8'd41);
    send_pixel(zcd_pkg::WHITE_LEVEL, 7'd43, 8'd63);
    send_pixel(zcd_pkg::BLACK_LEVEL, 7'd43, 8'd64);
    send_frame_end(16'd5, 16'd7, 1'b0, 1'b1, 1'b1, 1'b0);
    wait_idle();
    program_regs(make_regs(127, 127, 254, 254, 1023, LEG_MAX, LEG_MAX, LEG_MAX));
    send_pixel(zcd_pkg::WHITE_LEVEL, 7'd127, 8'd254);
    send_pixel(zcd_pkg::BLACK_LEVEL, 7'd127, 8'd255);
    send_pixel(zcd_pkg::WHITE_LEVEL, 7'd126, 8'd254);
    send_pixel(zcd_pkg::BLACK_LEVEL, 7'd126, 8'd255);
    send_pixel(zcd_pkg::WHITE_LEVEL, 7'd127, 8'd253);
    send_pixel(zcd_pkg::BLACK_LEVEL, 7'd127, 8'd254);
    send_frame_end(16'd0, 16'd0, 1'b0, 1'b1, 1'b0, 1'b0);
  endtask

  // long run of transitions over the whole frame in one count
  task automatic test_long_count();
    wait_idle();
    program_regs(make_regs(0, 127, 0, 255, 1023, LEG_MAX, LEG_MAX, LEG_MAX));
    for (int i = 0; i < 150; i++) begin
      send_pixel(zcd_pkg::WHITE_LEVEL, 7'(i), 8'((2 * i) % 254));
      send_pixel(zcd_pkg::BLACK_LEVEL, 7'(i), 8'((2 * i) % 254 + 1));
    end
    send_frame_end(16'd3, 16'd4, 1'b0, 1'b1, 1'b0, 1'b0);
  endtask

  // threshold 1023 keeps the search state; other_active swings the sum both ways
  task automatic test_distance_swing();
    wait_idle();
    program_regs(make_regs(25, 43, 30, 63, 1023, LEG_MAX, LEG_MAX, LEG_MAX));
    idle_on = 1'b0;
    for (int i = 0; i < 20; i++)
      send_frame_end(16'h7FFF, 16'h7FFF, 1'($urandom), 1'($urandom), 1'b1, i == 0);
    for (int i = 0; i < 20; i++)
      send_frame_end(16'h8000, 16'h8000, 1'($urandom), 1'($urandom), 1'b1, i == 0);
    send_frame_end(16'h7FFF, 16'h7FFF, 1'b0, 1'b1, 1'b1, 1'b0);
    idle_on = 1'b1;
  endtask

  // stall the output while frame ends keep coming so the input backs up
  task automatic test_backpressure();
    wait_idle();
    idle_on = 1'b0;
    hold_request = 1'b1;
    for (int i = 0; i < 60; i++) begin
      send_pixel(zcd_pkg::WHITE_LEVEL, 7'd30, 8'd40);
      send_random_frame_end();
    end
    idle_on = 1'b1;
  endtask

  task automatic test_random_walk();
    int start;
    for (int phase = 0; phase < 12; phase++) begin
      wait_idle();
      program_regs(random_regs(phase == 11));
      start = items_sent;
      while (items_sent - start < 100) begin
        send_stripes($urandom_range(0, 24));
        if ($urandom_range(0, 6) != 0)
          send_random_frame_end();
      end
    end
  endtask

  // zero legs and threshold: walk whatever state is left into the stop
  task automatic test_stop_sequence();
    int n;
    wait_idle();
    idle_on = 1'b0;
    program_regs(make_regs(25, 43, 30, 63, 0, 0, 0, 0));
    n = 0;
    while (model_state != zcd_pkg::ST_STOPPED && n < 12) begin
      send_pixel(zcd_pkg::WHITE_LEVEL, 7'd30, 8'd40);
      send_pixel(zcd_pkg::BLACK_LEVEL, 7'd30, 8'd41);
      send_frame_end(16'd100, 16'd100, 1'b0, 1'b1, 1'b0, 1'b0);
      n++;
    end
    for (int i = 0; i < 6; i++) begin
      send_stripes($urandom_range(0, 8));
      send_random_frame_end();
    end
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = zcd_pkg::KIND_PIXEL;
    cfg_we        = 1'b0;
    cfg_addr      = zcd_pkg::REG_ROW_FIRST;
    cfg_data      = '0;
    idle_on       = 1'b1;
    hold_request  = 1'b0;
    model_regs    = make_regs(zcd_pkg::RST_ROW_FIRST, zcd_pkg::RST_ROW_LAST,
                              zcd_pkg::RST_COL_FIRST, zcd_pkg::RST_COL_LAST,
                              zcd_pkg::RST_THRESHOLD, zcd_pkg::RST_FIRST_LEG,
                              zcd_pkg::RST_SECOND_LEG, zcd_pkg::RST_STOP_LEG);
    model_was_white = 1'b0;
    model_stripes   = '0;
    model_distance  = 0;
    model_state     = zcd_pkg::ST_SEARCH;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_pixel_cases();
    test_window_extremes();
    test_long_count();
    test_distance_swing();
    test_backpressure();
    test_random_walk();
    test_stop_sequence();
    wait_idle();

    $display("Checked %0d frame results from %0d pixel and %0d frame-end transfers.",
             results_checked, pixels_sent, frames_sent);
    $display("Covered window edges, a long transition run, large distance swings,",
             " a long output stall and a crossing walk up to state %0d.", deepest_state);
    if (err_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin : sink_driver
    int gap;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_LONG) @(posedge clk);
        hold_request = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 17);
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    crossing_result_t want;
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      if (frame_results.size() == 0) begin
        $display("%0t: unexpected result transfer %h", $time, m_axis_tdata);
        err_count++;
      end else begin
        want = frame_results.pop_front();
        results_checked++;
        if (m_axis_tdata[2:0] !== want.state) begin
          $display("%0t: zebra_state expected %0d got %0d", $time, want.state,
                   m_axis_tdata[2:0]);
          err_count++;
        end
        if (m_axis_tdata[3] !== want.stop) begin
          $display("%0t: stop_pulse expected %0d got %0d", $time, want.stop,
                   m_axis_tdata[3]);
          err_count++;
        end
        if (m_axis_tdata[13:4] !== want.total) begin
          $display("%0t: transition_total expected %0d got %0d", $time, want.total,
                   m_axis_tdata[13:4]);
          err_count++;
        end
        if (m_axis_tdata[45:14] !== want.distance) begin
          $display("%0t: distance_sum expected %0d got %0d", $time,
                   $signed(want.distance), $signed(m_axis_tdata[45:14]));
          err_count++;
        end
      end
    end
  end

  initial begin
    #6000000;
    $display("%0t: run did not finish in time", $time);
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/zcd_pkg.sv
rtl/core/zcd_window_counter.sv
rtl/core/zcd_crossing_fsm.sv
rtl/core/zebra_crossing_detector.sv
tb/tb_zebra_crossing_detector.sv
